FILE: hw/rtl/point_rotate_project_defines.svh
// ----------------------------------------------------------------------------
// point_rotate_project_defines
// assertion macros shared by the point rotate and project block
// ----------------------------------------------------------------------------
`ifndef POINT_ROTATE_PROJECT_DEFINES_SVH
`define POINT_ROTATE_PROJECT_DEFINES_SVH

`ifndef SYNTHESIS
`define PRP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("point_rotate_project: check failed");
`define PRP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("point_rotate_project: check failed");
`else
`define PRP_ASSERT(lbl, prop)
`define PRP_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/prp_pkg.sv
// ----------------------------------------------------------------------------
// prp_pkg
// types and constants of the point rotate and project block
// ----------------------------------------------------------------------------
package prp_pkg;

  localparam int unsigned CoordWidth   = 24;
  localparam int unsigned TrigWidth    = 16;
  localparam int unsigned ScreenWidth  = 13;
  localparam int unsigned OffsetWidth  = 12;
  localparam int unsigned PixWidth     = 16;
  localparam int unsigned QuoWidth     = 16;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgCosTheta     = 3'd0,
    CfgSinTheta     = 3'd1,
    CfgCosDelta     = 3'd2,
    CfgSinDelta     = 3'd3,
    CfgScreenWidth  = 3'd4,
    CfgScreenHeight = 3'd5
  } cfg_idx_e;

  localparam logic [3:0] RectEarth  = 4'd2;
  localparam logic [3:0] RectFlight = 4'd10;

  localparam logic signed [PixWidth-1:0] PixMax = 16'sh7fff;
  localparam logic signed [PixWidth-1:0] PixMin = 16'sh8000;

  typedef struct packed {
    logic signed [CoordWidth-1:0] in_x;
    logic signed [CoordWidth-1:0] in_y;
    logic signed [CoordWidth-1:0] in_z;
    logic                         point_kind;
  } req_t;

  typedef struct packed {
    logic signed [PixWidth-1:0] left_px;
    logic signed [PixWidth-1:0] top_px;
    logic [3:0]                 rect_size;
    logic                       is_white;
  } res_t;

  typedef struct packed {
    logic valid;
    logic flight;
  } ctl_t;

  typedef struct packed {
    logic signed [TrigWidth-1:0] cos_theta;
    logic signed [TrigWidth-1:0] sin_theta;
    logic signed [TrigWidth-1:0] cos_delta;
    logic signed [TrigWidth-1:0] sin_delta;
    logic [ScreenWidth-1:0]      scr_width;
    logic [ScreenWidth-1:0]      scr_height;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    cos_theta:  16'sd16384,
    sin_theta:  16'sd0,
    cos_delta:  16'sd16384,
    sin_delta:  16'sd0,
    scr_width:  13'd800,
    scr_height: 13'd600
  };

endpackage

FILE: hw/rtl/point_rotate_project.sv
// ----------------------------------------------------------------------------
// point_rotate_project
// rotates a q.8 point by two view angles and projects it onto the window
// ----------------------------------------------------------------------------
// A point request is taken on every clock at which start is high; busy is
// never raised. Each request gives exactly one result, shown on res_o for
// a single cycle with done_o high, in request order. The receiver cannot
// stall the output. A request passes through one input register, two
// rotation units of two stages each, four projection stages and the 16-bit
// restoring divider (17 stages plus the output register). Configuration is
// written through cfg_valid_i, which is always ready; a write to an index
// beyond the six registers is dropped.
// ----------------------------------------------------------------------------
`include "point_rotate_project_defines.svh"

module point_rotate_project
  import prp_pkg::*;
#(
  parameter int unsigned TRIG_FRAC_BITS  = 14,
  parameter int          CAMERA_DISTANCE = 300
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  req_t                    req_i,
  output logic                    done_o,
  output res_t                    res_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  localparam int          DistQ8  = CAMERA_DISTANCE * 256;
  localparam int unsigned W1      = ((CoordWidth > 21) ? CoordWidth : 21) + 1;
  localparam int unsigned R1      = W1 + 17 - TRIG_FRAC_BITS;
  localparam int unsigned R2      = R1 + 17 - TRIG_FRAC_BITS;
  localparam int unsigned MagW    = R2 + 13;
  localparam int unsigned Latency = 1 + 2 + 2 + 4 + QuoWidth + 2;

  cfg_t cfg;

  ctl_t                     ctl0_d, ctl0_q;
  logic signed [W1-1:0]     x0_q, z0_q, z0_d;
  logic signed [CoordWidth-1:0] y0_q;

  ctl_t                     ctl1;
  logic signed [R1-1:0]     xr1, zr1;
  logic signed [CoordWidth-1:0] y1;

  ctl_t                     ctl2;
  logic signed [R2-1:0]     yr2, zr2;
  logic signed [R1-1:0]     xr2;

  ctl_t                     ctl3;
  logic [R2-1:0]            n3;
  logic [1:0][MagW-1:0]     mag3;
  logic [1:0]               neg3;

  assign busy = 1'b0;

  prp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register, camera shift on z
  always_comb begin
    ctl0_d.valid  = start && !busy;
    ctl0_d.flight = req_i.point_kind;
  end

  assign z0_d = W1'(req_i.in_z) - W1'(DistQ8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else begin
      ctl0_q <= ctl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q <= W1'(req_i.in_x);
    y0_q <= req_i.in_y;
    z0_q <= z0_d;
  end

  // rotation in the x/z plane
  prp_rotate #(
    .AW      (W1),
    .BW      (W1),
    .CARRY_W (CoordWidth),
    .FRAC    (TRIG_FRAC_BITS),
    .OW      (R1)
  ) u_rot_theta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl0_q),
    .a_i     (x0_q),
    .b_i     (z0_q),
    .cos_i   (cfg.cos_theta),
    .sin_i   (cfg.sin_theta),
    .carry_i (y0_q),
    .ctl_o   (ctl1),
    .p_o     (xr1),
    .q_o     (zr1),
    .carry_o (y1)
  );

  // rotation in the y/z plane
  prp_rotate #(
    .AW      (CoordWidth),
    .BW      (R1),
    .CARRY_W (R1),
    .FRAC    (TRIG_FRAC_BITS),
    .OW      (R2)
  ) u_rot_delta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl1),
    .a_i     (y1),
    .b_i     (zr1),
    .cos_i   (cfg.cos_delta),
    .sin_i   (cfg.sin_delta),
    .carry_i (xr1),
    .ctl_o   (ctl2),
    .p_o     (yr2),
    .q_o     (zr2),
    .carry_o (xr2)
  );

  prp_project #(
    .XW   (R1),
    .YW   (R2),
    .DIST (CAMERA_DISTANCE)
  ) u_project (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl2),
    .xr_i         (xr2),
    .yr_i         (yr2),
    .zr_i         (zr2),
    .scr_width_i  (cfg.scr_width),
    .scr_height_i (cfg.scr_height),
    .ctl_o        (ctl3),
    .n_o          (n3),
    .mag_o        (mag3),
    .neg_o        (neg3)
  );

  prp_divide #(
    .NW (R2),
    .MW (MagW)
  ) u_divide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl3),
    .n_i    (n3),
    .mag_i  (mag3),
    .neg_i  (neg3),
    .done_o (done_o),
    .res_o  (res_o)
  );

  `PRP_ASSERT_IMP(a_latency, done_o, $past(start && !busy, Latency))
  `PRP_ASSERT_IMP(a_kind, done_o, res_o.is_white != $past(req_i.point_kind, Latency))
  `PRP_ASSERT_IMP(a_cfg_hold, !$past(cfg_valid_i && cfg_ready_o), $stable(cfg))

endmodule

FILE: hw/rtl/prp_cfg_regs.sv
// ----------------------------------------------------------------------------
// prp_cfg_regs
// view angle and window size registers with their write port
// ----------------------------------------------------------------------------
module prp_cfg_regs
  import prp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgCosTheta:     cfg_d.cos_theta  = cfg_data_i;
        CfgSinTheta:     cfg_d.sin_theta  = cfg_data_i;
        CfgCosDelta:     cfg_d.cos_delta  = cfg_data_i;
        CfgSinDelta:     cfg_d.sin_delta  = cfg_data_i;
        CfgScreenWidth:  cfg_d.scr_width  = cfg_data_i[ScreenWidth-1:0];
        CfgScreenHeight: cfg_d.scr_height = cfg_data_i[ScreenWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/prp_rotate.sv
// ----------------------------------------------------------------------------
// prp_rotate
// two-stage plane rotation: products, then sums with a flooring shift
// ----------------------------------------------------------------------------
module prp_rotate
  import prp_pkg::*;
#(
  parameter int unsigned AW      = 25,
  parameter int unsigned BW      = 25,
  parameter int unsigned CARRY_W = 24,
  parameter int unsigned FRAC    = 14,
  parameter int unsigned OW      = ((AW > BW) ? AW : BW) + 17 - FRAC
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctl_t                       ctl_i,
  input  logic signed [AW-1:0]       a_i,
  input  logic signed [BW-1:0]       b_i,
  input  logic signed [TrigWidth-1:0] cos_i,
  input  logic signed [TrigWidth-1:0] sin_i,
  input  logic signed [CARRY_W-1:0]  carry_i,
  output ctl_t                       ctl_o,
  output logic signed [OW-1:0]       p_o,
  output logic signed [OW-1:0]       q_o,
  output logic signed [CARRY_W-1:0]  carry_o
);

  localparam int unsigned IW = (AW > BW) ? AW : BW;
  localparam int unsigned PW = IW + TrigWidth;
  localparam int unsigned SW = PW + 1;

  logic signed [PW-1:0]      ac_d, bs_d, as_d, bc_d;
  logic signed [PW-1:0]      ac_q, bs_q, as_q, bc_q;
  logic signed [SW-1:0]      sp, sq;
  logic signed [OW-1:0]      p_d, q_d, p_q, q_q;
  logic signed [CARRY_W-1:0] carry1_q, carry2_q;
  ctl_t                      ctl1_q, ctl2_q;

  // products
  assign ac_d = PW'(a_i) * PW'(cos_i);
  assign bs_d = PW'(b_i) * PW'(sin_i);
  assign as_d = PW'(a_i) * PW'(sin_i);
  assign bc_d = PW'(b_i) * PW'(cos_i);

  // sums, floor shift back to q.8
  assign sp  = SW'(ac_q) + SW'(bs_q);
  assign sq  = SW'(bc_q) - SW'(as_q);
  assign p_d = OW'(sp >>> FRAC);
  assign q_d = OW'(sq >>> FRAC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ac_q     <= ac_d;
    bs_q     <= bs_d;
    as_q     <= as_d;
    bc_q     <= bc_d;
    carry1_q <= carry_i;
    p_q      <= p_d;
    q_q      <= q_d;
    carry2_q <= carry1_q;
  end

  assign ctl_o   = ctl2_q;
  assign p_o     = p_q;
  assign q_o     = q_q;
  assign carry_o = carry2_q;

endmodule

FILE: hw/rtl/prp_project.sv
// ----------------------------------------------------------------------------
// prp_project
// perspective denominator with clamp, numerators and their magnitudes
// ----------------------------------------------------------------------------
module prp_project
  import prp_pkg::*;
#(
  parameter int unsigned XW   = 28,
  parameter int unsigned YW   = 31,
  parameter int          DIST = 300
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ctl_t                        ctl_i,
  input  logic signed [XW-1:0]        xr_i,
  input  logic signed [YW-1:0]        yr_i,
  input  logic signed [YW-1:0]        zr_i,
  input  logic [ScreenWidth-1:0]      scr_width_i,
  input  logic [ScreenWidth-1:0]      scr_height_i,
  output ctl_t                        ctl_o,
  output logic [YW-1:0]               n_o,
  output logic [1:0][YW+12:0]         mag_o,
  output logic [1:0]                  neg_o
);

  localparam int          DistQ8  = DIST * 256;
  localparam int          NminRaw = DistQ8 / 10;
  localparam int          Nmin    = (NminRaw < 1) ? 1 : NminRaw;
  localparam int unsigned NSW     = YW + 1;
  localparam int unsigned AW      = YW + 14;
  localparam int unsigned MW      = AW - 1;
  localparam int unsigned OPW     = YW + OffsetWidth;

  localparam logic signed [13:0]    DistS = 14'(DIST);
  localparam logic signed [NSW-1:0] NminS = NSW'(Nmin);
  localparam logic signed [NSW-1:0] TwoDq = NSW'(2 * DistQ8);

  logic signed [NSW-1:0] nsum;
  logic [YW-1:0]         n_d, n_a_q, n_b_q, n_c_q, n_o_q;
  logic signed [XW-1:0]  xr_a_q;
  logic signed [YW-1:0]  yr_a_q;
  logic signed [AW-1:0]  px_d, py_d, px_b_q, py_b_q;
  logic [OPW-1:0]        ox_d, oy_d, ox_b_q, oy_b_q;
  logic signed [AW-1:0]  ax_d, ay_d, ax_c_q, ay_c_q;
  logic [1:0][MW-1:0]    mag_d, mag_q;
  logic [1:0]            neg_d, neg_q;
  ctl_t                  ctl_a_q, ctl_b_q, ctl_c_q, ctl_o_q;

  // denominator, clamped from below
  assign nsum = NSW'(zr_i) + TwoDq;
  assign n_d  = (nsum <= NminS) ? YW'(NminS) : YW'(nsum);

  // scaled coordinates and half-window times denominator
  assign px_d = AW'(xr_a_q) * AW'(DistS);
  assign py_d = AW'(yr_a_q) * AW'(DistS);
  assign ox_d = OPW'(n_a_q) * OPW'(scr_width_i[ScreenWidth-1:1]);
  assign oy_d = OPW'(n_a_q) * OPW'(scr_height_i[ScreenWidth-1:1]);

  // numerators, y flipped
  assign ax_d = $signed(AW'(ox_b_q)) + px_b_q;
  assign ay_d = $signed(AW'(oy_b_q)) - py_b_q;

  // sign and magnitude
  assign neg_d[0] = ax_c_q[AW-1];
  assign neg_d[1] = ay_c_q[AW-1];
  assign mag_d[0] = MW'(ax_c_q[AW-1] ? -ax_c_q : ax_c_q);
  assign mag_d[1] = MW'(ay_c_q[AW-1] ? -ay_c_q : ay_c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
      ctl_c_q <= '0;
      ctl_o_q <= '0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
      ctl_c_q <= ctl_b_q;
      ctl_o_q <= ctl_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n_a_q  <= n_d;
    xr_a_q <= xr_i;
    yr_a_q <= yr_i;
    n_b_q  <= n_a_q;
    px_b_q <= px_d;
    py_b_q <= py_d;
    ox_b_q <= ox_d;
    oy_b_q <= oy_d;
    n_c_q  <= n_b_q;
    ax_c_q <= ax_d;
    ay_c_q <= ay_d;
    n_o_q  <= n_c_q;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
  end

  assign ctl_o = ctl_o_q;
  assign n_o   = n_o_q;
  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

FILE: hw/rtl/prp_divide.sv
// ----------------------------------------------------------------------------
// prp_divide
// two-lane pipelined restoring divider, one quotient bit per stage,
// with overflow check, truncation toward zero and 16-bit saturation
// ----------------------------------------------------------------------------
module prp_divide
  import prp_pkg::*;
#(
  parameter int unsigned NW = 31,
  parameter int unsigned MW = 44
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_t                ctl_i,
  input  logic [NW-1:0]       n_i,
  input  logic [1:0][MW-1:0]  mag_i,
  input  logic [1:0]          neg_i,
  output logic                done_o,
  output res_t                res_o
);

  localparam int unsigned DW     = NW + QuoWidth + 1;
  localparam int unsigned Stages = QuoWidth + 1;
  localparam int unsigned Last   = Stages - 1;

  localparam logic [QuoWidth-1:0] NegLimit = 16'h8000;
  localparam logic [QuoWidth-1:0] PosLimit = 16'h7fff;

  logic [1:0][DW-1:0]       rem_d [Stages];
  logic [1:0][DW-1:0]       rem_q [Stages];
  logic [1:0][QuoWidth-1:0] quo_d [Stages];
  logic [1:0][QuoWidth-1:0] quo_q [Stages];
  logic [1:0]               ovf_d [Stages];
  logic [1:0]               ovf_q [Stages];
  logic [1:0]               neg_d [Stages];
  logic [1:0]               neg_q [Stages];
  logic [NW-1:0]            n_d   [Stages];
  logic [NW-1:0]            n_q   [Stages];
  ctl_t                     ctl_d [Stages];
  ctl_t                     ctl_q [Stages];

  logic [1:0][PixWidth-1:0] pix;
  res_t                     res_d, res_q;
  logic                     done_q;

  always_comb begin
    logic [DW-1:0] shifted;
    logic          take;
    // entry stage: quotient too large for 16 bits
    for (int l = 0; l < 2; l++) begin
      rem_d[0][l] = DW'(mag_i[l]);
      ovf_d[0][l] = DW'(mag_i[l]) >= (DW'(n_i) << QuoWidth);
      quo_d[0][l] = '0;
    end
    neg_d[0] = neg_i;
    n_d[0]   = n_i;
    ctl_d[0] = ctl_i;
    // one quotient bit per stage, msb first
    for (int s = 1; s < Stages; s++) begin
      for (int l = 0; l < 2; l++) begin
        shifted     = DW'(n_q[s-1]) << (QuoWidth - s);
        take        = !ovf_q[s-1][l] && (rem_q[s-1][l] >= shifted);
        rem_d[s][l] = take ? (rem_q[s-1][l] - shifted) : rem_q[s-1][l];
        quo_d[s][l] = {quo_q[s-1][l][QuoWidth-2:0], take};
      end
      ovf_d[s] = ovf_q[s-1];
      neg_d[s] = neg_q[s-1];
      n_d[s]   = n_q[s-1];
      ctl_d[s] = ctl_q[s-1];
    end
  end

  // sign and saturation
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (neg_q[Last][l]) begin
        pix[l] = (ovf_q[Last][l] || (quo_q[Last][l] > NegLimit)) ?
                 PixMin : (~quo_q[Last][l] + QuoWidth'(1));
      end else begin
        pix[l] = (ovf_q[Last][l] || (quo_q[Last][l] > PosLimit)) ?
                 PixMax : quo_q[Last][l];
      end
    end
    res_d.left_px   = pix[0];
    res_d.top_px    = pix[1];
    res_d.rect_size = ctl_q[Last].flight ? RectFlight : RectEarth;
    res_d.is_white  = !ctl_q[Last].flight;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '{default: '0};
      done_q <= 1'b0;
    end else begin
      ctl_q  <= ctl_d;
      done_q <= ctl_q[Last].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
    neg_q <= neg_d;
    n_q   <= n_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: test/tb_point_rotate_project.sv
// ----------------------------------------------------------------------------
// tb_point_rotate_project
// self-checking bench for the point rotate and project block
// ----------------------------------------------------------------------------
// Points are fed through the start/busy port from a queue of pending requests.
// Each accepted request is projected by a behavioural copy of the block and
// its expected screen square is queued. Every done_o strobe is checked against
// the oldest expected square. The run goes through several view and window
// settings, written only while the block is drained: reset values, right
// angles, extreme and out-of-range trig words, zero and odd window sizes and
// random settings. Directed points cover the coordinate extremes, the clamped
// perspective denominator, saturation and both point kinds. They are followed
// by random scene points, points near the clamp and fully random points.
// ----------------------------------------------------------------------------
module tb_point_rotate_project;
  import prp_pkg::*;

  localparam int TrigFracBits   = 14;
  localparam int CameraDistance = 300;
  localparam int CamQ8          = CameraDistance * 256;
  localparam int ClampN         = CamQ8 / 10;
  localparam int ClampEdgeZ     = ClampN - CamQ8;
  localparam int SceneQ8        = 400 * 256;
  localparam int CoordMax       = 8388607;
  localparam int CoordMin       = -8388608;
  localparam int NumPhases      = 8;
  localparam int PhaseItems     = 88;
  localparam int DrainCycles    = 40;
  localparam int unsigned CycleLimit = 100000;

  localparam logic [CfgIdxWidth-1:0] CfgUnusedLo = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CfgUnusedHi = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  res_t res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  logic signed [TrigWidth-1:0] cos_t = CfgReset.cos_theta;
  logic signed [TrigWidth-1:0] sin_t = CfgReset.sin_theta;
  logic signed [TrigWidth-1:0] cos_d = CfgReset.cos_delta;
  logic signed [TrigWidth-1:0] sin_d = CfgReset.sin_delta;
  logic [ScreenWidth-1:0] scr_w = CfgReset.scr_width;
  logic [ScreenWidth-1:0] scr_h = CfgReset.scr_height;

  req_t point_q[$];
  res_t proj_q[$];
  int idle_pct = 34;
  int mismatches = 0;
  int unsigned cycles = 0;

  point_rotate_project #(
    .TRIG_FRAC_BITS (TrigFracBits),
    .CAMERA_DISTANCE(CameraDistance)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic res_t project_point(req_t p);
    longint x, y, z, xr, zr, yr, zd, n, offx, offy, sx, sy;
    res_t r;
    x = longint'(p.in_x);
    y = longint'(p.in_y);
    z = longint'(p.in_z) - CamQ8;
    xr = (x * cos_t + z * sin_t) >>> TrigFracBits;
    zr = (-x * sin_t + z * cos_t) >>> TrigFracBits;
    yr = (y * cos_d + zr * sin_d) >>> TrigFracBits;
    zd = (-y * sin_d + zr * cos_d) >>> TrigFracBits;
    n = 2 * CamQ8 + zd;
    if (n <= ClampN) begin
      n = longint'(ClampN);
    end
    offx = longint'(scr_w / 2);
    offy = longint'(scr_h / 2);
    sx = (xr * CameraDistance + offx * n) / n;
    sy = (-yr * CameraDistance + offy * n) / n;
    r.left_px = (sx > PixMax) ? PixMax : (sx < PixMin) ? PixMin : sx[15:0];
    r.top_px = (sy > PixMax) ? PixMax : (sy < PixMin) ? PixMin : sy[15:0];
    r.rect_size = p.point_kind ? RectFlight : RectEarth;
    r.is_white = !p.point_kind;
    return r;
  endfunction

  function automatic req_t mk_point(int x, int y, int z, logic kind);
    req_t p;
    p.in_x = x[CoordWidth-1:0];
    p.in_y = y[CoordWidth-1:0];
    p.in_z = z[CoordWidth-1:0];
    p.point_kind = kind;
    return p;
  endfunction

  function automatic req_t random_point();
    int unsigned pick;
    int x, y, z;
    pick = $urandom_range(99);
    x = $urandom;
    y = $urandom;
    z = $urandom;
    if (pick < 60) begin
      x = int'($urandom_range(2 * SceneQ8)) - SceneQ8;
      y = int'($urandom_range(2 * SceneQ8)) - SceneQ8;
      z = int'($urandom_range(2 * SceneQ8)) - SceneQ8;
    end else if (pick < 80) begin
      x = int'($urandom_range(2 * SceneQ8)) - SceneQ8;
      y = int'($urandom_range(2 * SceneQ8)) - SceneQ8;
      z = ClampEdgeZ + int'($urandom_range(4000)) - 2000;
    end
    return mk_point(x, y, z, 1'($urandom_range(1)));
  endfunction

  // request driver
  always @(posedge clk_i) begin : drive
    logic send;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        proj_q.push_back(project_point(req_i));
      end
      if (!start || !busy) begin
        send = (point_q.size() != 0) && ($urandom_range(99) >= idle_pct);
        if (send) begin
          req_i <= point_q.pop_front();
        end
        start <= send;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : check
    res_t want;
    if (rst_ni && done_o) begin
      if (proj_q.size() == 0) begin
        $display("%0t: unexpected result x %0d y %0d size %0d white %0d", $time,
                 res_o.left_px, res_o.top_px, res_o.rect_size, res_o.is_white);
        mismatches++;
      end else begin
        want = proj_q.pop_front();
        if (res_o.left_px !== want.left_px || res_o.top_px !== want.top_px ||
            res_o.rect_size !== want.rect_size || res_o.is_white !== want.is_white) begin
          $display("%0t: mismatch expected x %0d y %0d size %0d white %0d", $time,
                   want.left_px, want.top_px, want.rect_size, want.is_white);
          $display("%0t:          actual   x %0d y %0d size %0d white %0d", $time,
                   res_o.left_px, res_o.top_px, res_o.rect_size, res_o.is_white);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk_i); while (point_q.size() != 0 || start || proj_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CfgCosTheta:     cos_t = val;
      CfgSinTheta:     sin_t = val;
      CfgCosDelta:     cos_d = val;
      CfgSinDelta:     sin_d = val;
      CfgScreenWidth:  scr_w = val[ScreenWidth-1:0];
      CfgScreenHeight: scr_h = val[ScreenWidth-1:0];
      default: ;
    endcase
  endtask

  initial begin : stimulus
    logic [CfgDataWidth-1:0] ct, st, cd, sd;
    logic [ScreenWidth-1:0] w, h;
    int phase;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (phase = 0; phase < NumPhases; phase++) begin
      if (phase != 0) begin
        wait_idle();
        case (phase)
          1: begin
            ct = 16'sd0; st = 16'sd16384; cd = 16'sd0; sd = -16'sd16384;
            w = '0; h = '0;
          end
          2: begin
            ct = -16'sd16384; st = -16'sd16384; cd = 16'sd16384; sd = 16'sd16384;
            w = 13'd8191; h = 13'd1;
          end
          3: begin
            ct = 16'sd16384; st = 16'sd0; cd = -16'sd16384; sd = 16'sd0;
            w = 13'd4096; h = 13'd4095;
          end
          default: begin
            if (phase % 2 == 1) begin
              ct = 16'($urandom); st = 16'($urandom);
              cd = 16'($urandom); sd = 16'($urandom);
            end else begin
              ct = 16'(int'($urandom_range(32768)) - 16384);
              st = 16'(int'($urandom_range(32768)) - 16384);
              cd = 16'(int'($urandom_range(32768)) - 16384);
              sd = 16'(int'($urandom_range(32768)) - 16384);
            end
            w = 13'($urandom);
            h = 13'($urandom);
          end
        endcase
        write_reg(CfgCosTheta, ct);
        write_reg(CfgSinTheta, st);
        write_reg(CfgCosDelta, cd);
        write_reg(CfgSinDelta, sd);
        write_reg(CfgScreenWidth, {3'($urandom_range(7)), w});
        write_reg(CfgScreenHeight, {3'($urandom_range(7)), h});
        write_reg(CfgUnusedLo, 16'($urandom));
        write_reg(CfgUnusedHi, 16'($urandom));
        cfg_valid_i <= 1'b0;
      end

      idle_pct = (phase == 4) ? 0 : 34;

      if (phase == 0) begin
        point_q.push_back(mk_point(0, 0, 0, 1'b0));
        point_q.push_back(mk_point(0, 0, 0, 1'b1));
        point_q.push_back(mk_point(CoordMax, CoordMax, CoordMax, 1'b0));
        point_q.push_back(mk_point(CoordMin, CoordMin, CoordMin, 1'b1));
        point_q.push_back(mk_point(CoordMax, CoordMin, 0, 1'b0));
        point_q.push_back(mk_point(CoordMin, CoordMax, 0, 1'b1));
        point_q.push_back(mk_point(0, 0, CoordMax, 1'b0));
        point_q.push_back(mk_point(0, 0, CoordMin, 1'b1));
        point_q.push_back(mk_point(25600, -25600, 0, 1'b0));
        // perspective denominator at, just above and just below its floor
        point_q.push_back(mk_point(25600, 25600, ClampEdgeZ, 1'b0));
        point_q.push_back(mk_point(25600, 25600, ClampEdgeZ + 1, 1'b1));
        point_q.push_back(mk_point(25600, 25600, ClampEdgeZ - 1, 1'b0));
        point_q.push_back(mk_point(-25600, 25600, -CamQ8, 1'b1));
        // saturation both ways
        point_q.push_back(mk_point(CoordMax, CoordMax, ClampEdgeZ, 1'b0));
        point_q.push_back(mk_point(CoordMin, CoordMin, ClampEdgeZ, 1'b1));
        point_q.push_back(mk_point(1, -1, 1, 1'b0));
        point_q.push_back(mk_point(-1, 1, -1, 1'b1));
        point_q.push_back(mk_point(255, -255, 0, 1'b0));
        point_q.push_back(mk_point(CamQ8, CamQ8, -CamQ8, 1'b1));
        point_q.push_back(mk_point(-1, -1, -1, 1'b0));
      end
      repeat (PhaseItems) point_q.push_back(random_point());
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
